// ===== hw/rtl/rfbp_pkg.sv =====
// Shared types and constants for the frame body parser.
// Holds the request and result structs, state encodings and character codes.
// No dependencies.
`timescale 1ns / 1ps

package rfbp_pkg;

    // One request: a body byte with its framing information.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic [2:0] frame_kind;
    } t_request;

    // One result item.
    typedef struct packed {
        logic [1:0]         result_type;
        logic [7:0]         payload_byte;
        logic signed [63:0] int_value;
        logic               bool_value;
        logic [1:0]         error_code;
        logic [2:0]         kind_echo;
    } t_result;

    // Frame kinds.
    localparam logic [2:0] KIND_SIMPLE   = 3'd0;
    localparam logic [2:0] KIND_ERROR    = 3'd1;
    localparam logic [2:0] KIND_BIGNUM   = 3'd2;
    localparam logic [2:0] KIND_BULK     = 3'd3;
    localparam logic [2:0] KIND_BULK_ERR = 3'd4;
    localparam logic [2:0] KIND_INTEGER  = 3'd5;
    localparam logic [2:0] KIND_BOOLEAN  = 3'd6;
    localparam logic [2:0] KIND_NULL     = 3'd7;

    // Result types.
    localparam logic [1:0] RES_PAYLOAD = 2'd0;
    localparam logic [1:0] RES_DONE    = 2'd1;
    localparam logic [1:0] RES_FAILED  = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_INVALID = 2'd1;
    localparam logic [1:0] ERR_NUMBER  = 2'd2;
    localparam logic [1:0] ERR_LENGTH  = 2'd3;

    // Characters.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_F     = 8'h66;

    // Largest magnitudes for a positive and a negative 64-bit result.
    localparam logic [67:0] MAG_LIMIT_POS = 68'h0_7FFF_FFFF_FFFF_FFFF;
    localparam logic [67:0] MAG_LIMIT_NEG = 68'h0_8000_0000_0000_0000;

    // Frame parse phase.
    typedef enum logic [6:0] {
        PH_IDLE      = 7'b0000001,
        PH_LINE      = 7'b0000010,
        PH_LINE_LF   = 7'b0000100,
        PH_BULK_DATA = 7'b0001000,
        PH_BULK_CR   = 7'b0010000,
        PH_BULK_LF   = 7'b0100000,
        PH_DROP      = 7'b1000000
    } t_phase;

    // Number scanner stage.
    typedef enum logic [3:0] {
        NS_SKIP   = 4'b0001,
        NS_SIGN   = 4'b0010,
        NS_DIGITS = 4'b0100,
        NS_END    = 4'b1000
    } t_nstage;

    // Decimal number scanner state.
    typedef struct packed {
        logic [63:0] magnitude;
        logic        negative;
        t_nstage     stage;
        logic        overflowed;
    } t_num_st;

endpackage

// ===== hw/rtl/resp_frame_body_parser.sv =====
// Frame body parser: throughput is one request per cycle, sustained while the
// result side takes results. Every request passes an input register, then one
// pass of parse logic updates the frame state and loads the result register.
// Reset (synchronous, active low) empties both registers and returns the
// parser to idle, waiting for a frame start.
`timescale 1ns / 1ps

module resp_frame_body_parser #(
    parameter int LEN_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_stall,
    input  rfbp_pkg::t_request i_req,
    output logic               o_rsp_valid,
    input  logic               i_rsp_stall,
    output rfbp_pkg::t_result  o_rsp
);
    import rfbp_pkg::*;

    // Input register holding one accepted request until it is parsed.
    logic      r_in_valid;
    t_request  r_in;

    // Result register facing the output channel.
    logic      r_out_valid;
    t_result   r_out;

    logic      proc_go;
    logic      has_result;
    t_result   result;

    // A request is parsed when the result register is free, or is being
    // emptied this cycle. Requests that cause no result still need this slot
    // so that the result order stays the request order.
    assign proc_go     = r_in_valid && (!r_out_valid || !i_rsp_stall);

    // The input register can take a new request whenever it is empty or its content moves on.
    assign o_req_stall = r_in_valid && !proc_go;

    rfbp_ctl #(
        .LEN_BITS (LEN_BITS)
    ) u_ctl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (proc_go),
        .i_req        (r_in),
        .o_has_result (has_result),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req_valid && !o_req_stall) begin
            r_in_valid <= 1'b1;
        end else if (proc_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_valid && !o_req_stall) begin
            r_in <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go) begin
            r_out_valid <= has_result;
        end else if (!i_rsp_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && has_result) begin
            r_out <= result;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

// ===== hw/rtl/rfbp_num.sv =====
// Decimal number scanner step: advances the scanner state by one character.
// Depends on rfbp_pkg.
`timescale 1ns / 1ps

module rfbp_num (
    input  rfbp_pkg::t_num_st i_num,
    input  logic [7:0]        i_char,
    output rfbp_pkg::t_num_st o_num
);
    import rfbp_pkg::*;

    logic        is_digit;
    logic        is_blank;
    logic [3:0]  digit;
    logic [67:0] wide_mag;
    logic [67:0] product;
    logic [67:0] limit;
    t_num_st     acc;

    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_blank = (i_char == CH_SPACE) || (i_char == CH_TAB) ||
                      (i_char == CH_VT) || (i_char == CH_FF);
    assign digit    = 4'(i_char - CH_ZERO);
    assign wide_mag = {4'b0, i_num.magnitude};
    // Times ten plus the digit; exceeding the limit is exactly the overflow test.
    assign product  = (wide_mag << 3) + (wide_mag << 1) + {64'b0, digit};
    assign limit    = i_num.negative ? MAG_LIMIT_NEG : MAG_LIMIT_POS;

    always_comb begin
        acc       = i_num;
        acc.stage = NS_DIGITS;
        if (!i_num.overflowed) begin
            if (product > limit) begin
                acc.overflowed = 1'b1;
            end else begin
                acc.magnitude = product[63:0];
            end
        end
    end

    always_comb begin
        o_num = i_num;
        case (i_num.stage)
            NS_SKIP: begin
                if (is_blank) begin
                    o_num = i_num;
                end else if ((i_char == CH_PLUS) || (i_char == CH_MINUS)) begin
                    o_num.negative = (i_char == CH_MINUS);
                    o_num.stage    = NS_SIGN;
                end else if (is_digit) begin
                    o_num = acc;
                end else begin
                    o_num.overflowed = 1'b1;
                    o_num.stage      = NS_END;
                end
            end
            NS_SIGN: begin
                if (is_digit) begin
                    o_num = acc;
                end else begin
                    o_num.overflowed = 1'b1;
                    o_num.stage      = NS_END;
                end
            end
            NS_DIGITS: begin
                if (is_digit) begin
                    o_num = acc;
                end else begin
                    o_num.stage = NS_END;
                end
            end
            default: begin
                o_num = i_num;
            end
        endcase
    end

endmodule

// ===== hw/rtl/rfbp_ctl.sv =====
// Frame parse state and per-byte decision logic.
// Depends on rfbp_pkg and rfbp_num.
`timescale 1ns / 1ps

module rfbp_ctl #(
    parameter int LEN_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  rfbp_pkg::t_request i_req,
    output logic               o_has_result,
    output rfbp_pkg::t_result  o_result
);
    import rfbp_pkg::*;

    t_phase              r_phase, n_phase;
    logic [2:0]          r_kind, n_kind;
    t_num_st             r_num, n_num;
    logic [LEN_BITS-1:0] r_remain, n_remain;
    logic [1:0]          r_line_cnt, n_line_cnt;
    logic [7:0]          r_first_char, n_first_char;

    // State as seen by this byte, after a frame start has taken effect.
    t_phase              c_phase;
    logic [2:0]          c_kind;
    t_num_st             c_num;
    logic [LEN_BITS-1:0] c_remain;
    logic [1:0]          c_line_cnt;
    logic [7:0]          c_first_char;

    t_num_st             num_step;
    logic [7:0]          ch;
    logic                bad_num;
    logic                len_too_big;
    logic [LEN_BITS-1:0] remain_dec;

    localparam t_num_st NUM_RESET = '{magnitude: 64'd0, negative: 1'b0,
                                      stage: NS_SKIP, overflowed: 1'b0};

    assign ch = i_req.data_byte;

    always_comb begin
        if (i_req.frame_start) begin
            c_phase      = PH_LINE;
            c_kind       = i_req.frame_kind;
            c_num        = NUM_RESET;
            c_remain     = '0;
            c_line_cnt   = 2'd0;
            c_first_char = 8'd0;
        end else begin
            c_phase      = r_phase;
            c_kind       = r_kind;
            c_num        = r_num;
            c_remain     = r_remain;
            c_line_cnt   = r_line_cnt;
            c_first_char = r_first_char;
        end
    end

    rfbp_num u_num (
        .i_num  (c_num),
        .i_char (ch),
        .o_num  (num_step)
    );

    assign bad_num     = ((c_num.stage != NS_DIGITS) && (c_num.stage != NS_END)) ||
                         c_num.overflowed;
    assign len_too_big = |c_num.magnitude[63:LEN_BITS];
    assign remain_dec  = c_remain - 1'b1;

    always_comb begin
        n_phase      = c_phase;
        n_kind       = c_kind;
        n_num        = c_num;
        n_remain     = c_remain;
        n_line_cnt   = c_line_cnt;
        n_first_char = c_first_char;
        o_has_result = 1'b0;
        o_result     = '0;
        o_result.kind_echo = c_kind;

        case (c_phase)
            PH_LINE: begin
                if (ch == CH_CR) begin
                    n_phase = PH_LINE_LF;
                end else if (ch == CH_LF) begin
                    n_phase             = PH_DROP;
                    o_has_result        = 1'b1;
                    o_result.result_type = RES_FAILED;
                    o_result.error_code  = ERR_INVALID;
                end else begin
                    case (c_kind)
                        KIND_SIMPLE, KIND_ERROR, KIND_BIGNUM: begin
                            o_has_result          = 1'b1;
                            o_result.result_type  = RES_PAYLOAD;
                            o_result.payload_byte = ch;
                        end
                        KIND_BULK, KIND_BULK_ERR, KIND_INTEGER: begin
                            n_num = num_step;
                        end
                        KIND_BOOLEAN: begin
                            if (c_line_cnt == 2'd0) begin
                                n_first_char = ch;
                            end
                            if (c_line_cnt != 2'd2) begin
                                n_line_cnt = c_line_cnt + 2'd1;
                            end
                        end
                        default: begin
                            n_num = c_num;
                        end
                    endcase
                end
            end
            PH_LINE_LF: begin
                o_has_result = 1'b1;
                if (ch != CH_LF) begin
                    n_phase              = PH_DROP;
                    o_result.result_type = RES_FAILED;
                    o_result.error_code  = ERR_INVALID;
                end else begin
                    case (c_kind)
                        KIND_BULK, KIND_BULK_ERR: begin
                            if (bad_num) begin
                                n_phase              = PH_DROP;
                                o_result.result_type = RES_FAILED;
                                o_result.error_code  = ERR_NUMBER;
                            end else if ((c_num.negative && (c_num.magnitude != 64'd0)) ||
                                         len_too_big) begin
                                n_phase              = PH_DROP;
                                o_result.result_type = RES_FAILED;
                                o_result.error_code  = ERR_LENGTH;
                            end else begin
                                o_has_result = 1'b0;
                                n_remain     = c_num.magnitude[LEN_BITS-1:0];
                                n_phase      = (c_num.magnitude == 64'd0) ?
                                               PH_BULK_CR : PH_BULK_DATA;
                            end
                        end
                        KIND_INTEGER: begin
                            if (bad_num) begin
                                n_phase              = PH_DROP;
                                o_result.result_type = RES_FAILED;
                                o_result.error_code  = ERR_NUMBER;
                            end else begin
                                n_phase              = PH_IDLE;
                                o_result.result_type = RES_DONE;
                                o_result.int_value   = c_num.negative ?
                                    $signed(64'd0 - c_num.magnitude) :
                                    $signed(c_num.magnitude);
                            end
                        end
                        KIND_BOOLEAN: begin
                            if ((c_line_cnt != 2'd1) ||
                                ((c_first_char != CH_T) && (c_first_char != CH_F))) begin
                                n_phase              = PH_DROP;
                                o_result.result_type = RES_FAILED;
                                o_result.error_code  = ERR_INVALID;
                            end else begin
                                n_phase              = PH_IDLE;
                                o_result.result_type = RES_DONE;
                                o_result.bool_value  = (c_first_char == CH_T);
                            end
                        end
                        default: begin
                            n_phase              = PH_IDLE;
                            o_result.result_type = RES_DONE;
                        end
                    endcase
                end
            end
            PH_BULK_DATA: begin
                n_remain = remain_dec;
                if (remain_dec == '0) begin
                    n_phase = PH_BULK_CR;
                end
                o_has_result          = 1'b1;
                o_result.result_type  = RES_PAYLOAD;
                o_result.payload_byte = ch;
            end
            PH_BULK_CR: begin
                if (ch != CH_CR) begin
                    n_phase              = PH_DROP;
                    o_has_result         = 1'b1;
                    o_result.result_type = RES_FAILED;
                    o_result.error_code  = ERR_INVALID;
                end else begin
                    n_phase = PH_BULK_LF;
                end
            end
            PH_BULK_LF: begin
                o_has_result = 1'b1;
                if (ch != CH_LF) begin
                    n_phase              = PH_DROP;
                    o_result.result_type = RES_FAILED;
                    o_result.error_code  = ERR_INVALID;
                end else begin
                    n_phase              = PH_IDLE;
                    o_result.result_type = RES_DONE;
                end
            end
            default: begin
                // Idle or dropping after a failure: the byte is discarded.
                n_phase = c_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_kind       <= KIND_SIMPLE;
            r_num        <= NUM_RESET;
            r_remain     <= '0;
            r_line_cnt   <= 2'd0;
            r_first_char <= 8'd0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_kind       <= n_kind;
            r_num        <= n_num;
            r_remain     <= n_remain;
            r_line_cnt   <= n_line_cnt;
            r_first_char <= n_first_char;
        end
    end

endmodule
